>>> rtl/core/bmm_pkg.sv
// Shared types and constants for the banked memory mapper.
package bmm_pkg;

  localparam int CartEnableBitDef = 6;
  localparam int PageBitsDef      = 8;

  localparam int AddrW     = 16;
  localparam int DataW     = 8;
  localparam int MediaW    = 22;
  localparam int WorkAddrW = 13;
  localparam int BankAddrW = 15;
  localparam int OffW      = 14;
  localparam int CfgIdxW   = 2;

  localparam logic [CfgIdxW-1:0] CFG_ALT_MODE   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BANK_MASK  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MEDIA_CTRL = 2'd2;

  localparam logic [DataW-1:0] BANK_MASK_RST  = 8'hFF;
  localparam logic [DataW-1:0] MEDIA_CTRL_RST = 8'hBF;
  localparam logic [DataW-1:0] CART_OFF_DATA  = 8'hFF;

  localparam logic [AddrW-1:0] ADDR_SEL_CTRL = 16'hFFFC;
  localparam logic [AddrW-1:0] ADDR_PAGE0    = 16'hFFFD;
  localparam logic [AddrW-1:0] ADDR_PAGE1    = 16'hFFFE;
  localparam logic [AddrW-1:0] ADDR_PAGE2    = 16'hFFFF;
  localparam logic [AddrW-1:0] ADDR_ALT0     = 16'h0000;
  localparam logic [AddrW-1:0] ADDR_ALT1     = 16'h4000;
  localparam logic [AddrW-1:0] ADDR_ALT2     = 16'h8000;
  localparam logic [AddrW-1:0] FIXED_LIMIT   = 16'h0400;
  localparam logic [WorkAddrW-1:0] WORK_CTRL_BYTE = 13'h1FFC;

  typedef enum logic [0:0] {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    SEL_NONE  = 2'd0,
    SEL_BANK0 = 2'd1,
    SEL_BANK1 = 2'd2
  } ram_sel_t;

  typedef enum logic [1:0] {
    SRC_IMM  = 2'd0,
    SRC_WORK = 2'd1,
    SRC_BANK = 2'd2
  } rd_src_t;

  typedef struct packed {
    logic                 rd_en;
    logic                 work_we;
    logic                 bank_we;
    logic [WorkAddrW-1:0] work_addr;
    logic [BankAddrW-1:0] bank_addr;
    logic [DataW-1:0]     wdata;
  } mem_req_t;

  typedef struct packed {
    rd_src_t           src;
    logic [DataW-1:0]  imm_data;
    logic              from_media;
    logic [MediaW-1:0] media_address;
  } rsp_sel_t;

endpackage

>>> rtl/core/bmm_req_if.sv
// Access request channel: cmd, address and write byte.
interface bmm_req_if import bmm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [AddrW-1:0] address;
  logic [DataW-1:0] write_data;

  modport source (output valid, cmd, address, write_data, input ready);
  modport sink   (input valid, cmd, address, write_data, output ready);
endinterface

>>> rtl/core/bmm_rsp_if.sv
// Access result channel: read byte and cartridge fetch address.
interface bmm_rsp_if import bmm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DataW-1:0]  read_data;
  logic              from_media;
  logic [MediaW-1:0] media_address;

  modport source (output valid, read_data, from_media, media_address, input ready);
  modport sink   (input valid, read_data, from_media, media_address, output ready);
endinterface

>>> rtl/core/bmm_mem.sv
// Work RAM and cartridge RAM banks with clearing sweep after reset.
module bmm_mem import bmm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  mem_req_t         req,
  output logic [DataW-1:0] work_rd,
  output logic [DataW-1:0] bank_rd,
  output logic             busy
);

  logic [DataW-1:0] work_ram [2**WorkAddrW];
  logic [DataW-1:0] bank_ram [2**BankAddrW];
  logic [BankAddrW-1:0] clr_cnt;
  logic                 clearing;

  assign busy = clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + BankAddrW'(1);
      if (clr_cnt == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      work_ram[clr_cnt[WorkAddrW-1:0]] <= '0;
    end else if (req.work_we) begin
      work_ram[req.work_addr] <= req.wdata;
    end
    if (req.rd_en) begin
      work_rd <= work_ram[req.work_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      bank_ram[clr_cnt] <= '0;
    end else if (req.bank_we) begin
      bank_ram[req.bank_addr] <= req.wdata;
    end
    if (req.rd_en) begin
      bank_rd <= bank_ram[req.bank_addr];
    end
  end

endmodule

>>> rtl/core/bmm_map.sv
// Config and paging registers, address decode and memory request forming.
module bmm_map import bmm_pkg::*; #(
  parameter int CART_ENABLE_BIT = CartEnableBitDef,
  parameter int PAGE_BITS       = PageBitsDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_en,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [DataW-1:0]   cfg_data,
  input  logic               accept,
  input  logic               cmd,
  input  logic [AddrW-1:0]   address,
  input  logic [DataW-1:0]   write_data,
  output mem_req_t           mem_req,
  output rsp_sel_t           sel
);

  localparam logic [DataW-1:0] PageMask =
    (PAGE_BITS >= DataW) ? '1 : DataW'((1 << PAGE_BITS) - 1);

  logic             alt_mode;
  logic [DataW-1:0] bank_mask;
  logic [DataW-1:0] media_ctrl;
  logic [DataW-1:0] page_regs [3];
  ram_sel_t         ram_sel;
  logic             ctrl_bit3;

  logic [DataW-1:0] page;
  logic [OffW-1:0]  off;
  logic [1:0]       slot;
  logic             is_wr;
  logic             bank_hit;
  logic             cart_on;
  logic [MediaW-1:0] maddr;

  assign page     = write_data & bank_mask & PageMask;
  assign off      = address[OffW-1:0];
  assign slot     = address[AddrW-1:OffW];
  assign is_wr    = (cmd == CMD_WRITE);
  assign bank_hit = (slot == 2'd2) && (ram_sel != SEL_NONE);
  assign cart_on  = !media_ctrl[CART_ENABLE_BIT];

  always_ff @(posedge clk) begin
    if (rst) begin
      alt_mode   <= 1'b0;
      bank_mask  <= BANK_MASK_RST;
      media_ctrl <= MEDIA_CTRL_RST;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_ALT_MODE:   alt_mode   <= cfg_data[0];
        CFG_BANK_MASK:  bank_mask  <= cfg_data;
        CFG_MEDIA_CTRL: media_ctrl <= cfg_data;
        default: ;
      endcase
    end
  end

  // paging side effects of writes; ctrl_bit3 shadows bit 3 of work RAM byte 1FFC
  always_ff @(posedge clk) begin
    if (rst) begin
      page_regs[0] <= 8'd0;
      page_regs[1] <= 8'd1;
      page_regs[2] <= 8'd2;
      ram_sel      <= SEL_NONE;
      ctrl_bit3    <= 1'b0;
    end else if (accept && is_wr) begin
      if (!alt_mode) begin
        if (address == ADDR_SEL_CTRL) begin
          if (write_data[3]) begin
            ram_sel <= write_data[2] ? SEL_BANK1 : SEL_BANK0;
          end else begin
            ram_sel <= SEL_NONE;
          end
        end else if (address == ADDR_PAGE0) begin
          page_regs[0] <= page;
        end else if (address == ADDR_PAGE1) begin
          page_regs[1] <= page;
        end else if (address == ADDR_PAGE2 && !ctrl_bit3) begin
          page_regs[2] <= page;
        end
      end else begin
        if (address == ADDR_ALT0) begin
          page_regs[0] <= page;
        end else if (address == ADDR_ALT1) begin
          page_regs[1] <= page;
        end else if (address == ADDR_ALT2) begin
          page_regs[2] <= page;
        end
      end
      if (slot == 2'd3 && address[WorkAddrW-1:0] == WORK_CTRL_BYTE) begin
        ctrl_bit3 <= write_data[3];
      end
    end
  end

  always_comb begin
    mem_req.rd_en     = accept && !is_wr;
    mem_req.work_we   = accept && is_wr && (slot == 2'd3);
    mem_req.bank_we   = accept && is_wr && bank_hit;
    mem_req.work_addr = address[WorkAddrW-1:0];
    mem_req.bank_addr = {(ram_sel == SEL_BANK1), off};
    mem_req.wdata     = write_data;

    if (!alt_mode && address < FIXED_LIMIT) begin
      maddr = MediaW'(address);
    end else begin
      maddr = {page_regs[(slot == 2'd3) ? 2'd0 : slot], off};
    end

    sel.src           = SRC_IMM;
    sel.imm_data      = '0;
    sel.from_media    = 1'b0;
    sel.media_address = '0;
    if (!is_wr) begin
      if (slot == 2'd3) begin
        sel.src = SRC_WORK;
      end else if (bank_hit && !(!alt_mode && address < FIXED_LIMIT)) begin
        sel.src = SRC_BANK;
      end else if (cart_on) begin
        sel.from_media    = 1'b1;
        sel.media_address = maddr;
      end else begin
        sel.imm_data = CART_OFF_DATA;
      end
    end
  end

endmodule

>>> rtl/core/banked_memory_mapper_top.sv
// Banked memory mapper top level: handshake, pending stage and result register.
// Path: an accepted word passes the RAM read register, then the result register,
// which holds while the output stalls; one word per cycle is sustained while the
// output is not stalled. Reset: config and paging registers return to defaults,
// then a sweep of 32768 addresses zeroes both RAMs; no word is accepted until done.
module banked_memory_mapper_top import bmm_pkg::*; #(
  parameter int CART_ENABLE_BIT = CartEnableBitDef,
  parameter int PAGE_BITS       = PageBitsDef
) (
  input  logic               clk,
  input  logic               rst,
  bmm_req_if.sink            req,
  bmm_rsp_if.source          rsp,
  input  logic               cfg_write_en,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [DataW-1:0]   cfg_data
);

  mem_req_t         mem_req;
  rsp_sel_t         sel;
  rsp_sel_t         pend_sel;
  logic             pend_valid;
  logic [DataW-1:0] work_rd;
  logic [DataW-1:0] bank_rd;
  logic             busy;
  logic             accept;
  logic             can_move;
  logic [DataW-1:0] rd_next;

  logic              out_valid;
  logic [DataW-1:0]  read_data;
  logic              from_media;
  logic [MediaW-1:0] media_address;

  assign can_move  = !out_valid || rsp.ready;
  assign req.ready = !busy && (!pend_valid || can_move);
  assign accept    = req.valid && req.ready;

  bmm_map #(
    .CART_ENABLE_BIT (CART_ENABLE_BIT),
    .PAGE_BITS       (PAGE_BITS)
  ) u_map (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .accept       (accept),
    .cmd          (req.cmd),
    .address      (req.address),
    .write_data   (req.write_data),
    .mem_req      (mem_req),
    .sel          (sel)
  );

  bmm_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .req     (mem_req),
    .work_rd (work_rd),
    .bank_rd (bank_rd),
    .busy    (busy)
  );

  always_comb begin
    case (pend_sel.src)
      SRC_WORK: rd_next = work_rd;
      SRC_BANK: rd_next = bank_rd;
      default:  rd_next = pend_sel.imm_data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        pend_valid <= 1'b1;
      end else if (can_move) begin
        pend_valid <= 1'b0;
      end
      if (pend_valid && can_move) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_sel <= sel;
    end
    if (pend_valid && can_move) begin
      read_data     <= rd_next;
      from_media    <= pend_sel.from_media;
      media_address <= pend_sel.media_address;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.read_data     = read_data;
  assign rsp.from_media    = from_media;
  assign rsp.media_address = media_address;

endmodule

>>> bench/banked_memory_mapper_top_test.sv
// Self-checking testbench for the banked memory mapper: random and directed bus accesses.
module banked_memory_mapper_top_test;
  import bmm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] SLOT_RAM  = 2'd2;
  localparam logic [1:0] SLOT_WORK = 2'd3;
  localparam int         WORDS_PER_PHASE = 280;

  typedef struct packed {
    cmd_t             cmd;
    logic [AddrW-1:0] address;
    logic [DataW-1:0] data;
  } access_t;

  typedef struct packed {
    logic [DataW-1:0]  read_data;
    logic              from_media;
    logic [MediaW-1:0] media_address;
  } mapper_word_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_write_en;
  logic [CfgIdxW-1:0] cfg_index;
  logic [DataW-1:0]   cfg_data;

  bmm_req_if req_ch ();
  bmm_rsp_if rsp_ch ();

  banked_memory_mapper_top DUT (
    .clk          (clk),
    .rst          (rst),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // mapper state as seen by the predictor
  logic [DataW-1:0] work_mem [8192];
  logic [DataW-1:0] bank_mem [32768];
  logic [DataW-1:0] page_sel [3];
  ram_sel_t         slot3_sel;
  logic             alt_mode;
  logic [DataW-1:0] page_mask;
  logic [DataW-1:0] media_ctrl;

  access_t      access_q [$];
  mapper_word_t expected_words [$];
  int unsigned  queued_count = 0;
  int unsigned  result_count = 0;
  int unsigned  fail_count = 0;
  int unsigned  send_idle_pct = 12;
  int unsigned  recv_idle_pct = 58;

  always #6 clk = ~clk;

  function automatic mapper_word_t cart_fetch(logic [MediaW-1:0] maddr);
    mapper_word_t w;
    w = '0;
    if (media_ctrl[CartEnableBitDef]) begin
      w.read_data = CART_OFF_DATA;
    end else begin
      w.from_media    = 1'b1;
      w.media_address = maddr;
    end
    return w;
  endfunction

  function automatic mapper_word_t map_access(cmd_t cmd, logic [AddrW-1:0] addr,
                                              logic [DataW-1:0] data);
    mapper_word_t    w;
    logic [OffW-1:0] off;
    logic [DataW-1:0] page;
    logic [1:0]      slot;
    w    = '0;
    off  = addr[OffW-1:0];
    slot = addr[AddrW-1:OffW];
    page = data & page_mask;
    if (cmd == CMD_WRITE) begin
      if (!alt_mode) begin
        case (addr)
          ADDR_SEL_CTRL: slot3_sel = data[3] ? (data[2] ? SEL_BANK1 : SEL_BANK0) : SEL_NONE;
          ADDR_PAGE0:    page_sel[0] = page;
          ADDR_PAGE1:    page_sel[1] = page;
          ADDR_PAGE2:    if (!work_mem[WORK_CTRL_BYTE][3]) page_sel[2] = page;
          default: ;
        endcase
      end else begin
        case (addr)
          ADDR_ALT0: page_sel[0] = page;
          ADDR_ALT1: page_sel[1] = page;
          ADDR_ALT2: page_sel[2] = page;
          default: ;
        endcase
      end
      if (slot == SLOT_WORK) begin
        work_mem[addr[WorkAddrW-1:0]] = data;
      end else if (slot == SLOT_RAM && slot3_sel != SEL_NONE) begin
        bank_mem[{slot3_sel == SEL_BANK1, off}] = data;
      end
    end else if (!alt_mode && addr < FIXED_LIMIT) begin
      w = cart_fetch(MediaW'(addr));
    end else if (slot == SLOT_WORK) begin
      w.read_data = work_mem[addr[WorkAddrW-1:0]];
    end else if (slot == SLOT_RAM && slot3_sel != SEL_NONE) begin
      w.read_data = bank_mem[{slot3_sel == SEL_BANK1, off}];
    end else begin
      w = cart_fetch({page_sel[slot], off});
    end
    return w;
  endfunction

  function automatic access_t random_access();
    access_t     a;
    int unsigned pick;
    pick      = $urandom_range(99);
    a.cmd     = cmd_t'($urandom_range(1));
    a.address = AddrW'($urandom);
    a.data    = DataW'($urandom);
    if (pick < 15) begin
      a.cmd     = CMD_WRITE;
      a.address = {14'h3FFF, 2'($urandom)};
    end else if (pick < 25) begin
      a.cmd     = CMD_WRITE;
      a.address = {2'($urandom_range(2)), 14'h0000};
    end else if (pick < 35) begin
      a.cmd     = CMD_READ;
      a.address = AddrW'($urandom_range(16'h07FF));
    end else if (pick < 70) begin
      // dense offsets so reads land on earlier writes
      a.address[13:4] = '0;
    end
    return a;
  endfunction

  task automatic queue_access(cmd_t cmd, logic [AddrW-1:0] addr, logic [DataW-1:0] data);
    access_q.push_back('{cmd, addr, data});
    queued_count++;
  endtask

  task automatic wait_drained();
    while (result_count != queued_count) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [DataW-1:0] val);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= val;
    case (idx)
      CFG_ALT_MODE:   alt_mode   = val[0];
      CFG_BANK_MASK:  page_mask  = val;
      CFG_MEDIA_CTRL: media_ctrl = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic run_phase(logic alt, logic [DataW-1:0] mask, logic [DataW-1:0] media,
                           int unsigned send_idle, int unsigned recv_idle);
    write_reg(CFG_ALT_MODE, {7'd0, alt});
    write_reg(CFG_BANK_MASK, mask);
    write_reg(CFG_MEDIA_CTRL, media);
    send_idle_pct = send_idle;
    recv_idle_pct = recv_idle;
    repeat (WORDS_PER_PHASE) access_q.push_back(random_access());
    queued_count += WORDS_PER_PHASE;
    wait_drained();
  endtask

  always @(posedge clk) begin : drive_access
    access_t nxt;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_words.push_back(map_access(cmd_t'(req_ch.cmd), req_ch.address,
                                            req_ch.write_data));
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (access_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = access_q.pop_front();
          req_ch.valid      <= 1'b1;
          req_ch.cmd        <= nxt.cmd;
          req_ch.address    <= nxt.address;
          req_ch.write_data <= nxt.data;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_result
    mapper_word_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        result_count++;
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word: read_data %h from_media %b media_address %h",
                   $time, rsp_ch.read_data, rsp_ch.from_media, rsp_ch.media_address);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          if (rsp_ch.read_data !== want.read_data) begin
            $display("%0t: read_data expected %h actual %h",
                     $time, want.read_data, rsp_ch.read_data);
            fail_count++;
          end
          if (rsp_ch.from_media !== want.from_media) begin
            $display("%0t: from_media expected %b actual %b",
                     $time, want.from_media, rsp_ch.from_media);
            fail_count++;
          end
          if (rsp_ch.media_address !== want.media_address) begin
            $display("%0t: media_address expected %h actual %h",
                     $time, want.media_address, rsp_ch.media_address);
            fail_count++;
          end
        end
      end
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    rst               = 1'b1;
    cfg_write_en      = 1'b0;
    cfg_index         = CFG_ALT_MODE;
    cfg_data          = '0;
    req_ch.valid      = 1'b0;
    req_ch.cmd        = CMD_READ;
    req_ch.address    = '0;
    req_ch.write_data = '0;
    rsp_ch.ready      = 1'b0;
    foreach (work_mem[i]) work_mem[i] = '0;
    foreach (bank_mem[i]) bank_mem[i] = '0;
    page_sel[0] = 8'd0;
    page_sel[1] = 8'd1;
    page_sel[2] = 8'd2;
    slot3_sel   = SEL_NONE;
    alt_mode    = 1'b0;
    page_mask   = BANK_MASK_RST;
    media_ctrl  = MEDIA_CTRL_RST;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed pass under reset settings
    queue_access(CMD_READ,  16'h0000, 8'h00);
    queue_access(CMD_READ,  16'h03FF, 8'hFF);
    queue_access(CMD_READ,  16'h0400, 8'h00);
    queue_access(CMD_READ,  16'h7FFF, 8'h00);
    queue_access(CMD_READ,  16'hBFFF, 8'h00);
    queue_access(CMD_WRITE, ADDR_PAGE0, 8'hFF);
    queue_access(CMD_READ,  16'h0400, 8'h00);
    queue_access(CMD_READ,  16'h0100, 8'h00);
    queue_access(CMD_WRITE, ADDR_PAGE1, 8'h80);
    queue_access(CMD_READ,  16'h4000, 8'h00);
    queue_access(CMD_WRITE, ADDR_SEL_CTRL, 8'h08);
    queue_access(CMD_WRITE, 16'h8000, 8'hA5);
    queue_access(CMD_READ,  16'h8000, 8'h00);
    queue_access(CMD_WRITE, ADDR_SEL_CTRL, 8'h0C);
    queue_access(CMD_READ,  16'h8000, 8'h00);
    queue_access(CMD_WRITE, 16'hBFFF, 8'h5A);
    queue_access(CMD_READ,  16'hBFFF, 8'h00);
    // select byte has bit 3 set: the page 2 register write is blocked
    queue_access(CMD_WRITE, ADDR_PAGE2, 8'h03);
    queue_access(CMD_WRITE, ADDR_SEL_CTRL, 8'h00);
    queue_access(CMD_WRITE, ADDR_PAGE2, 8'h03);
    queue_access(CMD_READ,  16'h8000, 8'h00);
    queue_access(CMD_WRITE, 16'hC000, 8'h11);
    queue_access(CMD_READ,  16'hE000, 8'h00);
    queue_access(CMD_READ,  16'hDFFC, 8'h00);
    queue_access(CMD_WRITE, 16'h1234, 8'h77);
    queue_access(CMD_WRITE, 16'h9000, 8'h33);
    queue_access(CMD_READ,  16'h9000, 8'h00);
    wait_drained();

    run_phase(1'b0, 8'h0F, 8'h00, 12, 58);
    run_phase(1'b1, 8'hFF, 8'hBF, 12, 58);
    run_phase(1'b0, 8'h00, 8'hFF, 58, 12);
    run_phase(1'b1, DataW'($urandom), 8'h40, 58, 12);
    run_phase(1'b0, 8'hFF, DataW'($urandom), 0, 0);
    run_phase(1'b1, 8'h1F, 8'h00, 0, 0);

    repeat (10) @(posedge clk);
    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("banked_memory_mapper_top test passed");
    end else begin
      $display("banked_memory_mapper_top test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("banked_memory_mapper_top test failed");
    $finish;
  end

endmodule

>>> files.f
rtl/core/bmm_pkg.sv
rtl/core/bmm_req_if.sv
rtl/core/bmm_rsp_if.sv
rtl/core/bmm_mem.sv
rtl/core/bmm_map.sv
rtl/core/banked_memory_mapper_top.sv
bench/banked_memory_mapper_top_test.sv
